FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RAV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rav: same-cycle check failed");

// Next-cycle implication.
`define RAV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rav: next-cycle check failed");

`endif

FILE: rtl/core/rav_pkg.sv
package rav_pkg;

  localparam int TIME_W        = 64;
  localparam int RATE_W        = 63;
  localparam int UNIT_W        = TIME_W + 1;
  localparam int FRAC_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_INVERSE  = 2'd1,
    OP_STEP     = 2'd2,
    OP_SET_RATE = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_MUL,
    S_SUM,
    S_LAT,
    S_STEP,
    S_YDIFF,
    S_YLAT,
    S_YABS,
    S_DIV,
    S_QSGN,
    S_QADD,
    S_OUT
  } state_t;

  typedef struct packed {
    state_t  st;
    opcode_t op;
    logic    accept;
  } seq_ctl_t;

endpackage

FILE: rtl/core/rav_unit.sv
// Shared 65-bit adder/subtractor.
module rav_unit (
  input  logic [rav_pkg::UNIT_W-1:0] a,
  input  logic [rav_pkg::UNIT_W-1:0] b,
  input  logic                       sub,
  output logic [rav_pkg::UNIT_W-1:0] sum
);

  logic [rav_pkg::UNIT_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = a + b_op + {{(rav_pkg::UNIT_W-1){1'b0}}, sub};

endmodule

FILE: rtl/core/rav_ctrl.sv
// Sequencer: walks one item through the shared unit.
module rav_ctrl #(
  parameter int FRAC_BITS = rav_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rav_pkg::opcode_t  opcode,
  input  logic              rate_zero,
  input  logic              out_free,
  output rav_pkg::seq_ctl_t ctl
);

  localparam int MUL_STEPS = rav_pkg::RATE_W;
  localparam int DIV_STEPS = rav_pkg::TIME_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  rav_pkg::state_t  state_r, state_nxt;
  rav_pkg::opcode_t op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = '0;
    case (state_r)
      rav_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = opcode;
          if (opcode == rav_pkg::OP_INVERSE) begin
            state_nxt = rate_zero ? rav_pkg::S_OUT : rav_pkg::S_YDIFF;
          end else begin
            state_nxt = rav_pkg::S_DELTA;
          end
        end
      end
      rav_pkg::S_DELTA: state_nxt = rav_pkg::S_MUL;
      rav_pkg::S_MUL: begin
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = rav_pkg::S_SUM;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      rav_pkg::S_SUM: begin
        case (op_r)
          rav_pkg::OP_READ: state_nxt = rav_pkg::S_LAT;
          rav_pkg::OP_STEP: state_nxt = rav_pkg::S_STEP;
          default:          state_nxt = rav_pkg::S_OUT;
        endcase
      end
      rav_pkg::S_LAT, rav_pkg::S_STEP: state_nxt = rav_pkg::S_OUT;
      rav_pkg::S_YDIFF: state_nxt = rav_pkg::S_YLAT;
      rav_pkg::S_YLAT:  state_nxt = rav_pkg::S_YABS;
      rav_pkg::S_YABS:  state_nxt = rav_pkg::S_DIV;
      rav_pkg::S_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = rav_pkg::S_QSGN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      rav_pkg::S_QSGN: state_nxt = rav_pkg::S_QADD;
      rav_pkg::S_QADD: state_nxt = rav_pkg::S_OUT;
      rav_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = rav_pkg::S_IDLE;
        end
      end
      default: state_nxt = rav_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.st     = state_r;
    ctl.op     = op_r;
    ctl.accept = (state_r == rav_pkg::S_IDLE) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rav_pkg::S_IDLE;
      op_r    <= rav_pkg::OP_READ;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/rate_adjusted_virtual_clock.sv
// Rate-adjusted virtual clock: local ns timestamps to global time and back.
//   global = origin_global + floor((local - origin_local) * rate / 2^FRAC_BITS) - latency
// Input channel (in_valid / in_stall) carries one command item: read, inverse,
// step or set rate. Result channel (out_valid / out_stall) returns one item
// per command: result_time (global for read, local for inverse, else zero)
// and divide_error (inverse while rate is zero).
// cfg_we writes the latency correction; write it only while no item is in work.
// Timing: in_stall is low only in the idle state; one item at a time.
// Steps per command, all through the shared unit:
//   read, step:  delta, shift-add multiply, origin sum, latency or step, out
//   set rate:    delta, shift-add multiply, origin sum, out
//   inverse:     y difference, latency, magnitude, restoring divide (one
//                quotient bit a cycle over 64 + FRAC_BITS numerator bits),
//                quotient sign, origin add, out; with zero rate straight to out
// All of it runs through one 65-bit adder/subtractor.
// The result waits in an output register; a stalled receiver holds it, and
// the next item may be accepted and worked on meanwhile. Its finish waits
// until the register is free.
// Reset (rst_n low, synchronous): origins zero, rate one, latency zero.
`include "assert_macros.svh"

module rate_adjusted_virtual_clock #(
  parameter int FRAC_BITS = rav_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [63:0] in_local_time,
  input  logic signed [63:0] in_global_time,
  input  logic signed [63:0] in_step_amount,
  input  logic [62:0]        in_new_rate,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_time,
  output logic               out_divide_error,
  // configuration
  input  logic               cfg_we,
  input  logic signed [63:0] cfg_latency_correction
);

  localparam int TW    = rav_pkg::TIME_W;
  localparam int RW    = rav_pkg::RATE_W;
  localparam int UW    = rav_pkg::UNIT_W;
  localparam int NUM_W = TW + FRAC_BITS;   // dividend bits that can be nonzero
  localparam logic [RW-1:0] UNITY_RATE = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

  function automatic logic [UW-1:0] sx(input logic [TW-1:0] v);
    return {v[TW-1], v};
  endfunction

  rav_pkg::seq_ctl_t ctl;

  // architectural state
  logic [TW-1:0] origin_local_r, origin_local_nxt;
  logic [TW-1:0] origin_global_r, origin_global_nxt;
  logic [RW-1:0] rate_r, rate_nxt;
  logic [TW-1:0] lat_r, lat_nxt;

  // captured command
  logic [TW-1:0] local_r, local_nxt;
  logic [TW-1:0] global_r, global_nxt;
  logic [TW-1:0] step_r, step_nxt;
  logic [RW-1:0] new_rate_r, new_rate_nxt;

  // work registers
  logic [TW-1:0]    x_r, x_nxt;      // delta, then y, then |y|
  logic [UW-1:0]    hi_r, hi_nxt;    // product high part / remainder
  logic [RW-1:0]    lo_r, lo_nxt;    // multiplier bits out, product bits in
  logic [NUM_W-1:0] nq_r, nq_nxt;    // dividend bits out, quotient bits in
  logic [TW-1:0]    t_r, t_nxt;
  logic             neg_r, neg_nxt;
  logic [TW-1:0]    res_r, res_nxt;
  logic             err_r, err_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [TW-1:0] out_res_r, out_res_nxt;
  logic          out_err_r, out_err_nxt;

  logic [UW-1:0]      unit_a, unit_b, unit_sum;
  logic               unit_sub;
  logic [UW+RW-1:0]   prod;
  logic [TW-1:0]      scaled;
  logic               rate_zero;
  logic               out_free;
  logic               out_load;
  logic               div_take;
  logic               div_rem_ok;
  logic               rate_load;

  assign rate_zero = (rate_r == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (ctl.st == rav_pkg::S_OUT) && out_free;
  assign prod      = {hi_r, lo_r};
  assign scaled    = prod[FRAC_BITS +: TW];   // floor of signed product / 2^FRAC_BITS
  assign div_take  = !unit_sum[UW-1];         // no borrow: remainder >= rate

  rav_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .opcode    (rav_pkg::opcode_t'(in_opcode)),
    .rate_zero (rate_zero),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  rav_unit u_unit (
    .a   (unit_a),
    .b   (unit_b),
    .sub (unit_sub),
    .sum (unit_sum)
  );

  // Datapath: each sequencer state but idle and out sets up one pass through the shared unit.
  always_comb begin
    unit_a            = '0;
    unit_b            = '0;
    unit_sub          = 1'b0;
    origin_local_nxt  = origin_local_r;
    origin_global_nxt = origin_global_r;
    rate_nxt          = rate_r;
    lat_nxt           = cfg_we ? cfg_latency_correction : lat_r;
    local_nxt         = local_r;
    global_nxt        = global_r;
    step_nxt          = step_r;
    new_rate_nxt      = new_rate_r;
    x_nxt             = x_r;
    hi_nxt            = hi_r;
    lo_nxt            = lo_r;
    nq_nxt            = nq_r;
    t_nxt             = t_r;
    neg_nxt           = neg_r;
    res_nxt           = res_r;
    err_nxt           = err_r;

    if (ctl.accept) begin
      local_nxt    = in_local_time;
      global_nxt   = in_global_time;
      step_nxt     = in_step_amount;
      new_rate_nxt = in_new_rate;
      res_nxt      = '0;
      err_nxt      = (rav_pkg::opcode_t'(in_opcode) == rav_pkg::OP_INVERSE) && rate_zero;
    end

    case (ctl.st)
      rav_pkg::S_DELTA: begin
        // delta = local - origin_local; load multiplier
        unit_a   = sx(local_r);
        unit_b   = sx(origin_local_r);
        unit_sub = 1'b1;
        x_nxt    = unit_sum[TW-1:0];
        hi_nxt   = '0;
        lo_nxt   = rate_r;
      end
      rav_pkg::S_MUL: begin
        // signed delta times unsigned rate, LSB of rate first
        unit_a = hi_r;
        unit_b = lo_r[0] ? sx(x_r) : '0;
        hi_nxt = {unit_sum[UW-1], unit_sum[UW-1:1]};
        lo_nxt = {unit_sum[0], lo_r[RW-1:1]};
      end
      rav_pkg::S_SUM: begin
        unit_a = sx(origin_global_r);
        unit_b = sx(scaled);
        t_nxt  = unit_sum[TW-1:0];
        if (ctl.op == rav_pkg::OP_SET_RATE) begin
          // rebase without latency, then switch rate
          origin_global_nxt = unit_sum[TW-1:0];
          origin_local_nxt  = local_r;
          rate_nxt          = new_rate_r;
        end
      end
      rav_pkg::S_LAT: begin
        unit_a   = sx(t_r);
        unit_b   = sx(lat_r);
        unit_sub = 1'b1;
        res_nxt  = unit_sum[TW-1:0];
      end
      rav_pkg::S_STEP: begin
        // (g + lat) is the pre-latency sum, so only the offset is added
        unit_a            = sx(t_r);
        unit_b            = sx(step_r);
        origin_global_nxt = unit_sum[TW-1:0];
        origin_local_nxt  = local_r;
      end
      rav_pkg::S_YDIFF: begin
        unit_a   = sx(global_r);
        unit_b   = sx(origin_global_r);
        unit_sub = 1'b1;
        x_nxt    = unit_sum[TW-1:0];
      end
      rav_pkg::S_YLAT: begin
        unit_a = sx(x_r);
        unit_b = sx(lat_r);
        x_nxt  = unit_sum[TW-1:0];
      end
      rav_pkg::S_YABS: begin
        // magnitude, dividend = |y| * 2^FRAC_BITS
        unit_b   = sx(x_r);
        unit_sub = x_r[TW-1];
        x_nxt    = unit_sum[TW-1:0];
        neg_nxt  = x_r[TW-1];
        hi_nxt   = '0;
        nq_nxt   = {unit_sum[TW-1:0], {FRAC_BITS{1'b0}}};
      end
      rav_pkg::S_DIV: begin
        // restoring step; remainder stays below rate < 2^63
        unit_a   = {hi_r[TW-1:0], nq_r[NUM_W-1]};
        unit_b   = {2'b00, rate_r};
        unit_sub = 1'b1;
        hi_nxt   = {1'b0, div_take ? unit_sum[TW-1:0] : unit_a[TW-1:0]};
        nq_nxt   = {nq_r[NUM_W-2:0], div_take};
      end
      rav_pkg::S_QSGN: begin
        unit_b   = sx(nq_r[TW-1:0]);
        unit_sub = neg_r;
        t_nxt    = unit_sum[TW-1:0];
      end
      rav_pkg::S_QADD: begin
        unit_a  = sx(origin_local_r);
        unit_b  = sx(t_r);
        res_nxt = unit_sum[TW-1:0];
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
      out_err_nxt   = err_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_local_r  <= '0;
      origin_global_r <= '0;
      rate_r          <= UNITY_RATE;
      lat_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      origin_local_r  <= origin_local_nxt;
      origin_global_r <= origin_global_nxt;
      rate_r          <= rate_nxt;
      lat_r           <= lat_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    local_r    <= local_nxt;
    global_r   <= global_nxt;
    step_r     <= step_nxt;
    new_rate_r <= new_rate_nxt;
    x_r        <= x_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    nq_r       <= nq_nxt;
    t_r        <= t_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    out_res_r  <= out_res_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_stall         = (ctl.st != rav_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_time  = out_res_r;
  assign out_divide_error = out_err_r;

  // checker terms
  assign div_rem_ok = (hi_r[UW-1:TW-1] == 2'b00) && (hi_r[TW-1:0] < {1'b0, rate_r});
  assign rate_load  = (ctl.st == rav_pkg::S_SUM) && (ctl.op == rav_pkg::OP_SET_RATE);

  `RAV_ASSERT_IMP(a_err_zero_result, out_valid_r && out_err_r, out_res_r == '0)
  `RAV_ASSERT_IMP(a_rem_below_rate, ctl.st == rav_pkg::S_DIV, div_rem_ok)
  `RAV_ASSERT_NXT(a_rate_hold, !rate_load, $stable(rate_r))
  `RAV_ASSERT_NXT(a_finish_posts, out_load, out_valid_r && out_res_r == $past(res_r))

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int FRAC = rav_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [62:0] RATE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] UNITY_RATE = 63'd1 << FRAC;
  // settle time before cfg writes and at the end, longer than the longest item (inverse)
  localparam int SETTLE_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 238;

  // one result item as the block should return it
  typedef struct packed {
    logic [63:0] tm;
    logic        err;
  } clock_reading_t;

  // Tracks the clock mapping (origins, rate, latency) and holds the readings
  // still owed by the block, oldest first.
  class time_map_checker;
    logic [63:0]    latency;
    logic [63:0]    origin_local;
    logic [63:0]    origin_global;
    logic [63:0]    rate;
    clock_reading_t pending_readings[$];
    int             failures;

    function new();
      latency       = '0;
      origin_local  = '0;
      origin_global = '0;
      rate          = 64'd1 << FRAC;
      failures      = 0;
    endfunction

    function void set_latency(logic [63:0] v);
      latency = v;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // floor(delta * r / 2^FRAC), delta signed, r unsigned; low 64 bits kept
    function logic [63:0] scale_span(logic [63:0] delta, logic [63:0] r);
      logic [127:0] prod;
      prod = {{64{delta[63]}}, delta} * {64'd0, r};
      return prod[FRAC+63:FRAC];
    endfunction

    // trunc(y * 2^FRAC / r) toward zero, r nonzero; low 64 bits kept
    function logic [63:0] unscale_span(logic [63:0] y, logic [63:0] r);
      logic [63:0]  mag;
      logic [127:0] quo;
      mag = y[63] ? -y : y;
      quo = ({64'd0, mag} << FRAC) / {64'd0, r};
      return y[63] ? -quo[63:0] : quo[63:0];
    endfunction

    function logic [63:0] global_at(logic [63:0] loc);
      return origin_global + scale_span(loc - origin_local, rate) - latency;
    endfunction

    function void take_command(rav_pkg::opcode_t op, logic [63:0] loc, logic [63:0] glob,
                               logic [63:0] stp, logic [62:0] nr);
      clock_reading_t r;
      r = '0;
      case (op)
        rav_pkg::OP_READ: r.tm = global_at(loc);
        rav_pkg::OP_INVERSE: begin
          // zero rate: error flag, result zero, state untouched
          if (rate == 64'd0) r.err = 1'b1;
          else r.tm = origin_local + unscale_span(glob - origin_global + latency, rate);
        end
        rav_pkg::OP_STEP: begin
          origin_global = global_at(loc) + stp + latency;
          origin_local  = loc;
        end
        rav_pkg::OP_SET_RATE: begin
          // rebase without latency, then load the new rate
          origin_global = origin_global + scale_span(loc - origin_local, rate);
          origin_local  = loc;
          rate          = {1'b0, nr};
        end
        default: ;
      endcase
      pending_readings.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void compare_reading(logic [63:0] tm, logic err);
      clock_reading_t want;
      if (pending_readings.size() == 0) begin
        flag($sformatf("unexpected result item: result_time %h divide_error %b", tm, err));
      end else begin
        want = pending_readings.pop_front();
        if (tm !== want.tm)
          flag($sformatf("result_time mismatch: exp %h got %h", want.tm, tm));
        if (err !== want.err)
          flag($sformatf("divide_error mismatch: exp %b got %b", want.err, err));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = rav_pkg::OP_READ;
  logic [63:0] in_local_time = '0;
  logic [63:0] in_global_time = '0;
  logic [63:0] in_step_amount = '0;
  logic [62:0] in_new_rate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_time;
  logic        out_divide_error;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_latency_correction = '0;

  // idling odds in percent, changed per phase
  int idle_pct = 0;
  int stall_pct = 0;

  time_map_checker tracker = new();

  rate_adjusted_virtual_clock uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_opcode              (in_opcode),
    .in_local_time          (in_local_time),
    .in_global_time         (in_global_time),
    .in_step_amount         (in_step_amount),
    .in_new_rate            (in_new_rate),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_result_time        (out_result_time),
    .out_divide_error       (out_divide_error),
    .cfg_we                 (cfg_we),
    .cfg_latency_correction (cfg_latency_correction)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stall, independent of out_valid
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Monitor: values seen here are the ones present before this edge.
  // Result first: a result never belongs to an item accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall)
        tracker.compare_reading(out_result_time, out_divide_error);
      if (in_valid && in_stall === 1'b0)
        tracker.take_command(rav_pkg::opcode_t'(in_opcode), in_local_time, in_global_time,
                             in_step_amount, in_new_rate);
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // across back-to-back items unless an idle draw drops it first.
  task automatic send_cmd(rav_pkg::opcode_t op, logic [63:0] loc, logic [63:0] glob,
                          logic [63:0] stp, logic [62:0] nr);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_local_time  <= loc;
    in_global_time <= glob;
    in_step_amount <= stp;
    in_new_rate    <= nr;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // sender pauses until every owed reading has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_latency(logic [63:0] v);
    cfg_we                 <= 1'b1;
    cfg_latency_correction <= v;
    @(posedge clk);
    tracker.set_latency(v);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // times: mostly full random or near the current origin, some near zero, some extremes
  function automatic logic [63:0] pick_time(logic [63:0] anchor);
    logic [63:0] jitter;
    logic [63:0] w;
    jitter = {32'd0, $urandom_range(2000000)} - 64'd1000000;
    w      = rand_word();
    case ($urandom_range(9))
      0, 1, 2: return w;
      3, 4, 5: return anchor + jitter;
      6:       return anchor + {{24{w[39]}}, w[39:0]};
      7: begin
        case ($urandom_range(3))
          0:       return T_MAX;
          1:       return T_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return jitter;
    endcase
  endfunction

  function automatic logic [63:0] pick_step();
    logic [63:0] w;
    w = rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return {32'd0, $urandom_range(2000000)} - 64'd1000000;
      6, 7:             return w;
      8:                return w[0] ? T_MAX : T_MIN;
      default:          return {{24{w[39]}}, w[39:0]};
    endcase
  endfunction

  // rates: mostly near one, sometimes zero, tiny, huge or fully random
  function automatic logic [62:0] pick_rate();
    logic [63:0] w;
    logic [62:0] r;
    w = rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: r = UNITY_RATE + 63'($urandom_range(2097152)) - 63'd1048576;
      5: r = w[62:0];
      6: r = '0;
      7: r = 63'($urandom_range(1000, 1));
      8: begin
        case ($urandom_range(2))
          0:       r = RATE_MAX;
          1:       r = 63'd1;
          default: r = UNITY_RATE;
        endcase
      end
      default: r = {23'd0, w[39:0]};
    endcase
    return r;
  endfunction

  function automatic rav_pkg::opcode_t pick_op();
    int v;
    v = $urandom_range(99);
    if (v < 35) return rav_pkg::OP_READ;
    if (v < 70) return rav_pkg::OP_INVERSE;
    if (v < 85) return rav_pkg::OP_STEP;
    return rav_pkg::OP_SET_RATE;
  endfunction

  // One random phase: settle, load latency, set idling, then random items
  // anchored near the current origins so results stay meaningful.
  task automatic run_phase(int idle, int stall, logic [63:0] lat);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_latency(lat);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (ITEMS_PER_PHASE) begin
      send_cmd(pick_op(), pick_time(tracker.origin_local), pick_time(tracker.origin_global),
               pick_step(), pick_rate());
      // occasional full drain mid-phase
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_latency('0);

    // directed: field extremes at rate one, then zero rate, huge rate,
    // tiny rate (quotient wraps) and half rate (floor of a negative span)
    send_cmd(rav_pkg::OP_READ,     '0,        '0,      '0,     '0);
    send_cmd(rav_pkg::OP_READ,     T_MAX,     '0,      '0,     '0);
    send_cmd(rav_pkg::OP_READ,     T_MIN,     '0,      '0,     '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        '0,      '0,     '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        T_MAX,   '0,     '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        T_MIN,   '0,     '0);
    send_cmd(rav_pkg::OP_STEP,     64'd1000,  '0,      T_MAX,  '0);
    send_cmd(rav_pkg::OP_READ,     64'd1000,  '0,      '0,     '0);
    send_cmd(rav_pkg::OP_STEP,     T_MIN,     '0,      T_MIN,  '0);
    send_cmd(rav_pkg::OP_READ,     T_MAX,     '0,      '0,     '0);
    send_cmd(rav_pkg::OP_SET_RATE, '0,        '0,      '0,     '0);
    send_cmd(rav_pkg::OP_READ,     64'd12345, '0,      '0,     '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        64'd5,   '0,     '0);
    send_cmd(rav_pkg::OP_STEP,     64'd77,    '0,      64'd3,  '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        T_MAX,   '0,     '0);
    send_cmd(rav_pkg::OP_SET_RATE, 64'd100,   '0,      '0,     RATE_MAX);
    send_cmd(rav_pkg::OP_READ,     T_MAX,     '0,      '0,     '0);
    send_cmd(rav_pkg::OP_READ,     T_MIN,     '0,      '0,     '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        T_MIN,   '0,     '0);
    send_cmd(rav_pkg::OP_SET_RATE, '0,        '0,      '0,     63'd1);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        T_MAX,   '0,     '0);
    send_cmd(rav_pkg::OP_INVERSE,  '0,        '1,      '0,     '0);
    send_cmd(rav_pkg::OP_SET_RATE, '0,        '0,      '0,     UNITY_RATE >> 1);
    send_cmd(rav_pkg::OP_READ,     '1,        '0,      '0,     '0);
    send_cmd(rav_pkg::OP_SET_RATE, '0,        '0,      '0,     UNITY_RATE);

    // random phases across idling mixes and latency settings incl. extremes
    run_phase(0,  0,  64'd1500);
    run_phase(55, 0,  T_MAX);
    run_phase(0,  55, T_MIN);
    run_phase(9,  9,  rand_word());
    run_phase(0,  0,  '1);
    run_phase(9,  9,  '0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("rate_adjusted_virtual_clock test passed");
    end else begin
      $display("rate_adjusted_virtual_clock test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("rate_adjusted_virtual_clock test failed");
    $finish;
  end

endmodule
